// ----- src/strided_max_pool_core_defines.svh -----
// Assertion macros shared by the strided max pool RTL.
`ifndef STRIDED_MAX_POOL_CORE_DEFINES_SVH
`define STRIDED_MAX_POOL_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SMP_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SMP_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/smp_pkg.sv -----
package smp_pkg;

   // Pixel and result data width.
   localparam int DATA_W = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam int DIM_REG_W  = 9;
   localparam int KSIZE_W    = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYER_DIM   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_SIZE = 1'b1;

   localparam logic [DIM_REG_W-1:0] LAYER_DIM_RESET   = 9'd8;
   localparam logic [KSIZE_W-1:0]   KERNEL_SIZE_RESET = 2'd2;

   // Result queue.
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   // Kernel size decoded into the cases the datapath distinguishes.
   typedef struct packed {
      logic k_one;
      logic k_three;
   } smp_mode_type;

   // One pixel after the horizontal stage, on its way to the line stores.
   typedef struct packed {
      logic                     hdone;
      logic                     row_odd;
      logic                     row_zero;
      logic                     row_final;
      logic                     k_one;
      logic                     k_three;
      logic                     layer_end;
      logic signed [DATA_W-1:0] hmax;
   } smp_hstage_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pooled_max;
      logic                     last_in_layer;
   } smp_result_type;

   function automatic logic signed [DATA_W-1:0] smp_max(
      input logic signed [DATA_W-1:0] a,
      input logic signed [DATA_W-1:0] b
   );
      return (a > b) ? a : b;
   endfunction

endpackage

// ----- src/smp_if.sv -----
// Pixel channel into the block.
interface smp_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [smp_pkg::DATA_W-1:0] pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

// Pooled result channel out of the block.
interface smp_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [smp_pkg::DATA_W-1:0] pooled_max;
   logic                             last_in_layer;

   modport source (output valid, output pooled_max, output last_in_layer, input ready);
   modport sink   (input valid, input pooled_max, input last_in_layer, output ready);
endinterface

// ----- src/smp_horiz.sv -----
`include "strided_max_pool_core_defines.svh"

module smp_horiz #(
   parameter int MAX_DIM = 256,
   localparam int CNT_W = $clog2(MAX_DIM),
   localparam int AW    = $clog2(MAX_DIM / 2 + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  restart,
   input  logic                                  accept,
   input  logic signed [smp_pkg::DATA_W-1:0]     pixel,
   input  smp_pkg::smp_mode_type                 mode,
   input  logic [CNT_W-1:0]                      dim_last,
   output logic [AW-1:0]                         rd_addr,
   output logic                                  hs_valid,
   output smp_pkg::smp_hstage_type               hs,
   output logic [AW-1:0]                         hs_addr
);

   logic [CNT_W-1:0]                  col_ff, col_in;
   logic [CNT_W-1:0]                  row_ff, row_in;
   logic signed [smp_pkg::DATA_W-1:0] hm0_ff, hm0_in;
   logic signed [smp_pkg::DATA_W-1:0] hm1_ff, hm1_in;
   logic                              hs_valid_ff;
   smp_pkg::smp_hstage_type           hs_ff, hs_in;
   logic [AW-1:0]                     hs_addr_ff;
   logic                              col_end;
   logic                              row_end;
   logic                              hdone;

   assign col_end = (col_ff >= dim_last);
   assign row_end = (row_ff >= dim_last);

   // Line store column for this pixel; the read is issued on the transfer.
   assign rd_addr = AW'(col_ff >> 1);

   // Running horizontal maxima: slot 0 is the window being built, slot 1
   // holds the odd pixel that also opens the next window when k is 3.
   always_comb begin
      hm0_in = hm0_ff;
      hm1_in = hm1_ff;
      hdone  = 1'b0;
      if (!col_ff[0]) begin
         hm0_in = (mode.k_three && (col_ff != '0)) ? smp_pkg::smp_max(hm1_ff, pixel) : pixel;
         hm1_in = smp_pkg::MOST_NEG;
         hdone  = mode.k_one || col_end;
      end else if (!mode.k_one) begin
         hm0_in = smp_pkg::smp_max(hm0_ff, pixel);
         hm1_in = mode.k_three ? pixel : hm1_ff;
         hdone  = 1'b1;
      end
   end

   // Raster position in the layer.
   always_comb begin
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (col_end) begin
         col_in = '0;
         row_in = row_end ? '0 : row_ff + 1'b1;
      end
   end

   // Stage word handed to the line store side.
   always_comb begin
      hs_in.hdone     = hdone;
      hs_in.row_odd   = row_ff[0];
      hs_in.row_zero  = (row_ff == '0);
      hs_in.row_final = row_end;
      hs_in.k_one     = mode.k_one;
      hs_in.k_three   = mode.k_three;
      hs_in.layer_end = ((row_ff & ~CNT_W'(1)) == (dim_last & ~CNT_W'(1))) &&
                        ((col_ff & ~CNT_W'(1)) == (dim_last & ~CNT_W'(1)));
      hs_in.hmax      = hm0_in;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
         hm0_ff <= smp_pkg::MOST_NEG;
         hm1_ff <= smp_pkg::MOST_NEG;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
         hm0_ff <= hm0_in;
         hm1_ff <= hm1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_valid_ff <= 1'b0;
      end else begin
         hs_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hs_ff      <= hs_in;
         hs_addr_ff <= rd_addr;
      end
   end

   assign hs_valid = hs_valid_ff;
   assign hs       = hs_ff;
   assign hs_addr  = hs_addr_ff;

   // The position never runs past the configured layer.
   `SMP_ASSERT_IMP(a_col_in_layer, 1'b1, col_ff <= dim_last, "column counter beyond layer")
   `SMP_ASSERT_IMP(a_row_in_layer, 1'b1, row_ff <= dim_last, "row counter beyond layer")
   // A restart leaves the pending maximum empty.
   `SMP_ASSERT_NXT(a_restart_clears, restart, hm1_ff == smp_pkg::MOST_NEG, "maximum not cleared")

endmodule

// ----- src/smp_vert.sv -----
module smp_vert #(
   parameter int MAX_DIM = 256,
   localparam int LINE_DEPTH = MAX_DIM / 2 + 1,
   localparam int AW = $clog2(LINE_DEPTH)
) (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic [AW-1:0]           rd_addr,
   input  logic                    hs_valid,
   input  smp_pkg::smp_hstage_type hs,
   input  logic [AW-1:0]           hs_addr,
   output logic                    res_valid,
   output smp_pkg::smp_result_type res
);

   logic signed [smp_pkg::DATA_W-1:0] even_mem [LINE_DEPTH];
   logic signed [smp_pkg::DATA_W-1:0] odd_mem  [LINE_DEPTH];
   logic signed [smp_pkg::DATA_W-1:0] even_q_ff;
   logic signed [smp_pkg::DATA_W-1:0] odd_q_ff;
   logic signed [smp_pkg::DATA_W-1:0] acc;
   logic                              wr_even;
   logic                              wr_odd;
   logic                              vdone;

   // Vertical running maximum: even rows open or finish a window, odd rows
   // finish it, and with k of 3 an odd row also seeds the next window.
   always_comb begin
      acc     = hs.hmax;
      wr_even = 1'b0;
      wr_odd  = 1'b0;
      vdone   = 1'b0;
      if (hs_valid && hs.hdone) begin
         if (!hs.row_odd) begin
            acc     = (hs.k_three && !hs.row_zero) ? smp_pkg::smp_max(odd_q_ff, hs.hmax)
                                                   : hs.hmax;
            wr_even = 1'b1;
            vdone   = hs.k_one || hs.row_final;
         end else if (!hs.k_one) begin
            acc    = smp_pkg::smp_max(even_q_ff, hs.hmax);
            vdone  = 1'b1;
            wr_odd = hs.k_three;
         end
      end
   end

   // Line stores. A read issued while the stage ahead writes the same entry
   // takes the write data instead of the stale memory word.
   always_ff @(posedge clock) begin
      if (wr_even) begin
         even_mem[hs_addr] <= acc;
      end
      if (wr_odd) begin
         odd_mem[hs_addr] <= hs.hmax;
      end
      if (rd_en) begin
         even_q_ff <= (wr_even && (hs_addr == rd_addr)) ? acc : even_mem[rd_addr];
         odd_q_ff  <= (wr_odd && (hs_addr == rd_addr)) ? hs.hmax : odd_mem[rd_addr];
      end
   end

   assign res_valid         = vdone;
   assign res.pooled_max    = acc;
   assign res.last_in_layer = hs.layer_end;

endmodule

// ----- src/smp_out_queue.sv -----
`include "strided_max_pool_core_defines.svh"

module smp_out_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  smp_pkg::smp_result_type        push_data,
   output logic [smp_pkg::Q_CNT_W-1:0]    count,
   smp_rsp_if.source                      rsp
);

   smp_pkg::smp_result_type            entries_ff [smp_pkg::Q_DEPTH];
   logic [smp_pkg::Q_PTR_W-1:0]        wptr_ff, wptr_in;
   logic [smp_pkg::Q_PTR_W-1:0]        rptr_ff, rptr_in;
   logic [smp_pkg::Q_CNT_W-1:0]        count_ff, count_in;
   logic                               pop;

   assign pop = rsp.valid && rsp.ready;

   // Pointer and fill bookkeeping.
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wptr_ff] <= push_data;
      end
   end

   assign count             = count_ff;
   assign rsp.valid         = (count_ff != '0);
   assign rsp.pooled_max    = entries_ff[rptr_ff].pooled_max;
   assign rsp.last_in_layer = entries_ff[rptr_ff].last_in_layer;

   // A result is never pushed into a full queue.
   `SMP_ASSERT_IMP(a_q_no_overflow, push && !pop, count_ff != smp_pkg::Q_CNT_W'(smp_pkg::Q_DEPTH), "result queue overflow")
   // Pointers and fill count stay consistent.
   `SMP_ASSERT_IMP(a_q_ptr_match, count_ff == '0, wptr_ff == rptr_ff, "empty queue with pointer gap")

endmodule

// ----- src/strided_max_pool_core.sv -----
// Stride-two max pooling over square layers of signed pixels that arrive
// in raster order. The block takes one pixel per clock cycle while the
// result queue has room; a result reaches rsp_ch via the horizontal stage
// register, which also takes the line store read, then the result queue.
// req_ch.ready drops only when the four-entry result queue plus the pixel
// in the line store stage would leave no room, so with rsp_ch always
// ready the rate is one pixel per cycle. The vertical running maxima live
// in two line memories of MAX_DIM/2+1 words each; they need no clearing
// after reset since a layer processed from its start writes every entry
// before reading it. Any configuration write restarts the layer position.
`include "strided_max_pool_core_defines.svh"

module strided_max_pool_core #(
   parameter int MAX_DIM = 256
) (
   input  logic                              clock,
   input  logic                              reset,
   smp_req_if.sink                           req_ch,
   smp_rsp_if.source                         rsp_ch,
   input  logic                              csr_wr_en,
   input  logic [smp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [smp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int CNT_W = $clog2(MAX_DIM);
   localparam int AW    = $clog2(MAX_DIM / 2 + 1);

   logic [smp_pkg::DIM_REG_W-1:0] layer_dim_ff, layer_dim_in;
   logic [smp_pkg::KSIZE_W-1:0]   kernel_size_ff, kernel_size_in;
   logic [CNT_W-1:0]              dim_last;
   smp_pkg::smp_mode_type         mode;
   logic                          accept;
   logic [AW-1:0]                 rd_addr;
   logic                          hs_valid;
   smp_pkg::smp_hstage_type       hs;
   logic [AW-1:0]                 hs_addr;
   logic                          res_valid;
   smp_pkg::smp_result_type       res;
   logic [smp_pkg::Q_CNT_W-1:0]   q_count;

   // Configuration registers.
   always_comb begin
      layer_dim_in   = layer_dim_ff;
      kernel_size_in = kernel_size_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            smp_pkg::CSR_LAYER_DIM:   layer_dim_in   = csr_wdata[smp_pkg::DIM_REG_W-1:0];
            smp_pkg::CSR_KERNEL_SIZE: kernel_size_in = csr_wdata[smp_pkg::KSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_dim_ff   <= smp_pkg::LAYER_DIM_RESET;
         kernel_size_ff <= smp_pkg::KERNEL_SIZE_RESET;
      end else begin
         layer_dim_ff   <= layer_dim_in;
         kernel_size_ff <= kernel_size_in;
      end
   end

   // Effective layer side minus one; zero acts as one, oversize as MAX_DIM.
   always_comb begin
      if (layer_dim_ff == '0) begin
         dim_last = '0;
      end else if (32'(layer_dim_ff) > MAX_DIM) begin
         dim_last = CNT_W'(MAX_DIM - 1);
      end else begin
         dim_last = CNT_W'(layer_dim_ff - 1'b1);
      end
   end

   // Kernel size zero behaves as one.
   assign mode.k_one   = (kernel_size_ff <= smp_pkg::KSIZE_W'(1));
   assign mode.k_three = (kernel_size_ff == smp_pkg::KSIZE_W'(3));

   // Take a pixel only when its possible result has a queue slot reserved.
   assign req_ch.ready = (q_count + smp_pkg::Q_CNT_W'(hs_valid)) <
                         smp_pkg::Q_CNT_W'(smp_pkg::Q_DEPTH);
   assign accept       = req_ch.valid && req_ch.ready;

   smp_horiz #(
      .MAX_DIM (MAX_DIM)
   ) u_horiz (
      .clock    (clock),
      .reset    (reset),
      .restart  (csr_wr_en),
      .accept   (accept),
      .pixel    (req_ch.pixel_value),
      .mode     (mode),
      .dim_last (dim_last),
      .rd_addr  (rd_addr),
      .hs_valid (hs_valid),
      .hs       (hs),
      .hs_addr  (hs_addr)
   );

   smp_vert #(
      .MAX_DIM (MAX_DIM)
   ) u_vert (
      .clock     (clock),
      .rd_en     (accept),
      .rd_addr   (rd_addr),
      .hs_valid  (hs_valid),
      .hs        (hs),
      .hs_addr   (hs_addr),
      .res_valid (res_valid),
      .res       (res)
   );

   smp_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .count     (q_count),
      .rsp       (rsp_ch)
   );

   // A result can only come from a pixel in the line store stage.
   `SMP_ASSERT_IMP(a_result_has_pixel, res_valid, hs_valid && hs.hdone, "result without pixel")

endmodule

// ----- test/strided_max_pool_core_checker.sv -----
`timescale 1ns / 100ps

// Watches the pixel and result channels and the register port, predicts
// every pooled result, and compares each result transfer with the oldest
// prediction.
module pool_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   smp_req_if                             req_mon,
   smp_rsp_if                             rsp_mon,
   input  logic                           csr_wr_en,
   input  logic [smp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [smp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    results_owed
);

   import smp_pkg::*;

   localparam int unsigned MAX_SIDE   = 256;
   localparam int unsigned LINE_WORDS = MAX_SIDE / 2 + 1;
   localparam int unsigned REPORT_MAX = 10;

   typedef logic signed [DATA_W-1:0] pixel_t;

   // Predicted state of the pooling datapath.
   pixel_t              line_even [LINE_WORDS];
   pixel_t              line_odd  [LINE_WORDS];
   pixel_t              hmax_cur;
   pixel_t              hmax_pend;
   int unsigned         row_pos;
   int unsigned         col_pos;
   logic [DIM_REG_W-1:0] dim_reg;
   logic [KSIZE_W-1:0]  ksize_reg;

   smp_result_type      expected_pools [$];
   int unsigned         bad_count = 0;

   function automatic pixel_t larger(input pixel_t a, input pixel_t b);
      return (a > b) ? a : b;
   endfunction

   function automatic void restart_layer();
      row_pos   = 0;
      col_pos   = 0;
      hmax_cur  = MOST_NEG;
      hmax_pend = MOST_NEG;
   endfunction

   // Advances the layer position by one pixel and queues the pooled
   // result when this pixel completes a window.
   function automatic void pool_pixel(input pixel_t value);
      int unsigned    side;
      int unsigned    kern;
      int unsigned    slot;
      int unsigned    last_pos;
      int unsigned    out_row;
      int unsigned    out_col;
      logic           h_done;
      logic           v_done;
      pixel_t         window_max;
      smp_result_type res;

      side = (dim_reg == 0) ? 1 : ((dim_reg > MAX_SIDE) ? MAX_SIDE : int'(dim_reg));
      kern = (ksize_reg == 0) ? 1 : int'(ksize_reg);
      slot = (col_pos >> 1) % LINE_WORDS;
      last_pos = (side - 1) & ~32'd1;
      h_done = 1'b0;
      v_done = 1'b0;
      window_max = MOST_NEG;

      // Horizontal stage: even columns open a window, odd ones extend it.
      if (!col_pos[0]) begin
         hmax_cur  = (kern == 3 && col_pos > 0) ? larger(hmax_pend, value) : value;
         hmax_pend = MOST_NEG;
         h_done    = (kern == 1) || (col_pos == side - 1);
      end else if (kern >= 2) begin
         hmax_cur = larger(hmax_cur, value);
         h_done   = 1'b1;
         if (kern == 3) begin
            hmax_pend = value;
         end
      end

      // Vertical stage over the two line stores.
      if (h_done) begin
         if (!row_pos[0]) begin
            window_max = (kern == 3 && row_pos > 0) ? larger(line_odd[slot], hmax_cur)
                                                    : hmax_cur;
            line_even[slot] = window_max;
            v_done = (kern == 1) || (row_pos == side - 1);
         end else if (kern >= 2) begin
            window_max = larger(line_even[slot], hmax_cur);
            v_done     = 1'b1;
            if (kern == 3) begin
               line_odd[slot] = hmax_cur;
            end
         end
      end

      if (v_done) begin
         out_row = ((kern == 1 || !row_pos[0]) ? row_pos : row_pos - 1) & ~32'd1;
         out_col = ((kern == 1 || !col_pos[0]) ? col_pos : col_pos - 1) & ~32'd1;
         res.pooled_max    = window_max;
         res.last_in_layer = (out_row == last_pos) && (out_col == last_pos);
         expected_pools.push_back(res);
      end

      // Raster position, wrapping at the end of the layer.
      if (col_pos + 1 >= side) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= side) ? 0 : row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
   endfunction

   function automatic void flag_mismatch(input string what, input smp_result_type want);
      bad_count++;
      if (bad_count <= REPORT_MAX) begin
         $display("%0t: %s: got pooled_max %0d last_in_layer %b, expected %0d / %b",
                  $realtime, what, rsp_mon.pooled_max, rsp_mon.last_in_layer,
                  want.pooled_max, want.last_in_layer);
      end
   endfunction

   // All channel values are sampled at the rising edge, before the block
   // and the stimulus update them.
   always @(posedge clock) begin
      smp_result_type want;

      if (reset) begin
         dim_reg   = LAYER_DIM_RESET;
         ksize_reg = KERNEL_SIZE_RESET;
         restart_layer();
         expected_pools.delete();
      end else begin
         // Any register write also restarts the layer position.
         if (csr_wr_en) begin
            case (csr_index)
               CSR_LAYER_DIM:   dim_reg   = csr_wdata[DIM_REG_W-1:0];
               CSR_KERNEL_SIZE: ksize_reg = csr_wdata[KSIZE_W-1:0];
               default: ;
            endcase
            restart_layer();
         end

         if (req_mon.valid && req_mon.ready) begin
            pool_pixel(req_mon.pixel_value);
         end

         // Each result transfer is matched against the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pools.size() == 0) begin
               want.pooled_max    = 'x;
               want.last_in_layer = 1'bx;
               flag_mismatch("result with nothing pending", want);
            end else begin
               want = expected_pools.pop_front();
               if (rsp_mon.pooled_max !== want.pooled_max ||
                   rsp_mon.last_in_layer !== want.last_in_layer) begin
                  flag_mismatch("result mismatch", want);
               end
            end
         end
      end

      mismatches   <= bad_count;
      results_owed <= expected_pools.size();
   end

endmodule

// ----- test/strided_max_pool_core_test.sv -----
`timescale 1ns / 100ps

module strided_max_pool_core_test;

   localparam int unsigned MAX_SIDE      = 256;
   localparam int unsigned RANDOM_ITEMS  = 550;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned IDLE_LIMIT    = 2000;

   typedef logic signed [smp_pkg::DATA_W-1:0] pixel_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_CHOPPY,
      RX_STALLED
   } rx_mode_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_wr_en;
   logic [smp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [smp_pkg::CSR_DATA_W-1:0] csr_wdata;
   int unsigned                    mismatches;
   int unsigned                    results_owed;

   int unsigned           pixels_sent = 0;
   int unsigned           burst_left  = 0;
   bit                    steady_feed = 1'b0;
   int unsigned           side        = 1;

   smp_req_if req_ch ();
   smp_rsp_if rsp_ch ();

   strided_max_pool_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pool_result_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_ch),
      .rsp_mon      (rsp_ch),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .mismatches   (mismatches),
      .results_owed (results_owed)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Offers one pixel and waits for its transfer; between bursts the
   // sender drops valid for a random gap.
   task automatic send_pixel(input pixel_type value);
      int unsigned gap;
      req_ch.valid       <= 1'b1;
      req_ch.pixel_value <= value;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
      if (!steady_feed) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Holds the sender until every predicted result has been transferred.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [smp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [smp_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Registers change only once the block has gone idle.
   task automatic set_registers(input bit set_dim, input int unsigned dim,
                                input bit set_kernel, input int unsigned kernel);
      drain_results();
      if (set_dim) begin
         write_reg(smp_pkg::CSR_LAYER_DIM, smp_pkg::CSR_DATA_W'(dim));
         side = (dim == 0) ? 1 : ((dim > MAX_SIDE) ? MAX_SIDE : dim);
      end
      if (set_kernel) begin
         write_reg(smp_pkg::CSR_KERNEL_SIZE, smp_pkg::CSR_DATA_W'(kernel));
      end
   endtask

   // Mix of full-range values, the extremes and small values that tie.
   function automatic pixel_type pick_pixel();
      case ($urandom_range(0, 9))
         0:       return smp_pkg::MOST_NEG;
         1:       return 32'sh7fff_ffff;
         2:       return -32'sd1;
         3, 4:    return $signed(32'($urandom_range(0, 16))) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   // Result receiver: long open stretches, choppy stretches and stalls.
   initial begin : receiver
      rx_mode_type mode;
      int unsigned run_left;
      run_left = 0;
      mode     = RX_OPEN;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (run_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  mode     = RX_OPEN;
                  run_left = $urandom_range(1, 60);
               end
               4, 5, 6: begin
                  mode     = RX_CHOPPY;
                  run_left = $urandom_range(1, 40);
               end
               default: begin
                  mode     = RX_STALLED;
                  run_left = $urandom_range(1, 20);
               end
            endcase
         end
         run_left--;
         case (mode)
            RX_OPEN:    rsp_ch.ready <= 1'b1;
            RX_CHOPPY:  rsp_ch.ready <= $urandom_range(0, 1);
            default:    rsp_ch.ready <= 1'b0;
         endcase
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_ch.valid && req_ch.ready) ||
             (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      pixel_type   corner_vals [4];
      int unsigned i;
      int unsigned n;
      int unsigned phase;
      int unsigned big_phase;
      int unsigned dim_sel;
      int unsigned k_sel;

      corner_vals = '{smp_pkg::MOST_NEG, 32'sh7fff_ffff, 32'sd0, -32'sd1};

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.pixel_value <= '0;
      csr_wr_en          <= 1'b0;
      csr_index          <= smp_pkg::CSR_LAYER_DIM;
      csr_wdata          <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero dimension and zero kernel act as one.
      steady_feed = 1'b1;
      set_registers(1'b1, 0, 1'b1, 0);
      send_pixel(corner_vals[1]);

      // One-pixel layers with the widest kernel: every pixel ends a layer.
      set_registers(1'b1, 1, 1'b1, 3);
      for (i = 0; i < 4; i++) send_pixel(corner_vals[i]);

      // A 2x2 layer holding both extremes.
      steady_feed = 1'b0;
      set_registers(1'b1, 2, 1'b1, 2);
      for (i = 0; i < 4; i++) send_pixel(corner_vals[i]);

      // A 3x3 layer with kernel three and distinct values.
      set_registers(1'b1, 3, 1'b1, 3);
      for (i = 0; i < 9; i++) send_pixel($signed(32'((i * 37) % 11)) - 32'sd5);

      // Oversized dimensions clamp to the largest layer.
      set_registers(1'b1, 511, 1'b1, 1);
      for (i = 0; i < 4; i++) send_pixel(corner_vals[3 - i]);
      set_registers(1'b1, 257, 1'b1, 2);
      for (i = 0; i < 3; i++) send_pixel(pick_pixel());

      // Random phases of whole and partial layers; one phase uses the
      // largest side for a row and a bit.
      big_phase = $urandom_range(2, 4);
      phase     = 0;
      n         = pixels_sent + RANDOM_ITEMS;
      while (pixels_sent < n) begin
         phase++;
         steady_feed = ($urandom_range(0, 3) == 0);
         k_sel = $urandom_range(0, 3);
         if (phase == big_phase) begin
            case ($urandom_range(0, 2))
               0:       dim_sel = 256;
               1:       dim_sel = 257;
               default: dim_sel = 511;
            endcase
            set_registers(1'b1, dim_sel, 1'b1, k_sel);
            i = MAX_SIDE + $urandom_range(2, 64);
         end else begin
            dim_sel = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 16)
                                                  : $urandom_range(0, 12);
            case ($urandom_range(0, 3))
               0:       set_registers(1'b1, dim_sel, 1'b0, 0);
               1:       set_registers(1'b0, 0, 1'b1, k_sel);
               2:       set_registers(1'b1, dim_sel, 1'b1, k_sel);
               default: ;
            endcase
            i = (side > 12) ? side * side : side * side * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) begin
               i = $urandom_range(1, side * side);
            end
         end
         // The last phase stops at the planned pixel count.
         if (i > n - pixels_sent) begin
            i = n - pixels_sent;
         end
         repeat (i) begin
            send_pixel(pick_pixel());
            if ($urandom_range(0, 99) == 0) begin
               drain_results();
            end
         end
      end

      drain_results();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
